[hdl/lznt1_stream_decompressor_defines.svh]
// assertion helpers for the decompressor
`ifndef LZNT1_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZNT1_STREAM_DECOMPRESSOR_DEFINES_SVH

// property that must hold on every edge out of reset
`define LZD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lznt_pkg.sv]
package lznt_pkg;

  typedef enum logic [3:0] {
    PH_HDR_LO   = 4'd0,
    PH_HDR_HI   = 4'd1,
    PH_STORED   = 4'd2,
    PH_FLAGS    = 4'd3,
    PH_ITEM     = 4'd4,
    PH_TOKEN_HI = 4'd5,
    PH_SKIP     = 4'd6,
    PH_DONE     = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ENDED       = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_BAD_BACKREF = 3'd4,
    ST_BUSY        = 3'd5
  } status_t;

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  // length field width (offset shift) of a token, given bytes produced so far (>0)
  function automatic logic [3:0] token_shift(input logic [12:0] produced);
    logic [3:0] s;
    s = 4'd12;
    if (produced > 13'd0) begin
      if (produced - 13'd1 >= 13'd16)   s = 4'd11;
      if (produced - 13'd1 >= 13'd32)   s = 4'd10;
      if (produced - 13'd1 >= 13'd64)   s = 4'd9;
      if (produced - 13'd1 >= 13'd128)  s = 4'd8;
      if (produced - 13'd1 >= 13'd256)  s = 4'd7;
      if (produced - 13'd1 >= 13'd512)  s = 4'd6;
      if (produced - 13'd1 >= 13'd1024) s = 4'd5;
      if (produced - 13'd1 >= 13'd2048) s = 4'd4;
    end
    return s;
  endfunction

endpackage

[hdl/lznt_ram.sv]
module lznt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lznt1_stream_decompressor.sv]
// lznt1 stream decompressor
// input channel: in_valid/in_stall with in_action, in_in_byte, in_in_last.
//   a push request (action 0) carries one compressed byte, in_last marking
//   the final one; a drain request (action 1) emits the next back-reference
//   byte while out_copy_pending is high.
// result channel: out_valid/out_stall; exactly one result per request with
//   out_out_byte, out_out_valid, out_copy_pending, out_status, out_stream_done.
// no new request is taken while one is in progress; the history memory read
//   for a drain is registered, and the update and write-back follow on finish.
// the result register loads when the request finishes, which waits for a free
//   output register, and the result is offered from it.
// a result waits in the output register while the receiver stalls; the next
//   request is still taken and processed, and held in its final cycle until
//   the output register frees.
// errors (bad header, truncation, bad backref) stick until reset.
// reset clears all parser state; the 4096-byte history needs no clearing,
//   since an entry is only read after it has been written in the chunk.
module lznt1_stream_decompressor
  import lznt_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_in_byte,
  input  logic       in_in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_copy_pending,
  output logic [2:0] out_status,
  output logic       out_stream_done
);

  localparam int unsigned AW = $clog2(CHUNK_BYTES);

  // request staging
  logic       busy_r, busy_nxt;
  logic       act_r;
  logic [7:0] byte_r;
  logic       last_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_lo_r, hdr_lo_nxt;
  logic [12:0] chunk_left_r, chunk_left_nxt;
  logic [7:0]  flag_bits_r, flag_bits_nxt;
  logic [2:0]  flag_idx_r, flag_idx_nxt;
  logic [12:0] produced_r, produced_nxt;
  logic [7:0]  tok_lo_r, tok_lo_nxt;
  logic [12:0] copy_left_r, copy_left_nxt;
  logic [12:0] copy_dist_r, copy_dist_nxt;
  status_t     sticky_r, sticky_nxt;

  logic        ovld_r;
  logic [7:0]  obyte_r;
  logic        opend_r;
  logic [2:0]  ostat_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic        finish;
  logic        r_ov;
  logic [7:0]  r_ob;
  status_t     r_stat;

  lznt_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // the staged request finishes once the output slot is free
  assign finish   = busy_r && (!out_valid || !out_stall);
  assign in_stall = busy_r;
  assign raddr    = AW'(produced_r - copy_dist_r);

  // decode one request against the parser state
  always_comb begin
    logic [15:0] hdr;
    logic [15:0] tok;
    logic [3:0]  sh;
    logic [12:0] len, off, room;
    phase_t      ph_was;
    logic [13:0] sum;
    phase_nxt      = phase_r;
    hdr_lo_nxt     = hdr_lo_r;
    chunk_left_nxt = chunk_left_r;
    flag_bits_nxt  = flag_bits_r;
    flag_idx_nxt   = flag_idx_r;
    produced_nxt   = produced_r;
    tok_lo_nxt     = tok_lo_r;
    copy_left_nxt  = copy_left_r;
    copy_dist_nxt  = copy_dist_r;
    sticky_nxt     = sticky_r;
    we    = 1'b0;
    waddr = AW'(produced_r);
    wdata = byte_r;
    r_ov  = 1'b0;
    r_ob  = 8'd0;
    r_stat = ST_OK;
    hdr  = {byte_r, hdr_lo_r};
    tok  = {byte_r, tok_lo_r};
    sh   = token_shift(produced_r);
    len  = 13'((16'h0FFF >> (4'd12 - sh)) & tok) + 13'd3;
    off  = 13'(tok >> sh) + 13'd1;
    room = 13'(CHUNK_BYTES) - produced_r;
    ph_was = phase_r;
    sum = 14'd0;
    if (finish && sticky_r == ST_OK) begin
      if (act_r == ACT_DRAIN) begin
        if (copy_left_r != 13'd0) begin
          we   = 1'b1;
          wdata = rdata;
          r_ob = rdata;
          r_ov = 1'b1;
          produced_nxt  = produced_r + 13'd1;
          copy_left_nxt = copy_left_r - 13'd1;
        end
      end else if (copy_left_r != 13'd0) begin
        r_stat = ST_BUSY;
      end else if (phase_r != PH_DONE) begin
        case (phase_r)
          PH_HDR_LO: begin
            hdr_lo_nxt = byte_r;
            phase_nxt  = PH_HDR_HI;
          end
          PH_HDR_HI: begin
            if (hdr == 16'd0) begin
              phase_nxt = PH_DONE;
            end else if ((hdr & 16'h7000) != 16'h3000) begin
              sticky_nxt = ST_BAD_HEADER;
            end else begin
              chunk_left_nxt = 13'(hdr & 16'h0FFF) + 13'd1;
              produced_nxt   = 13'd0;
              phase_nxt      = hdr[15] ? PH_FLAGS : PH_STORED;
            end
          end
          PH_STORED: begin
            chunk_left_nxt = chunk_left_r - 13'd1;
            if (chunk_left_nxt == 13'd0) phase_nxt = PH_HDR_LO;
            r_ov = 1'b1;
            r_ob = byte_r;
          end
          PH_FLAGS: begin
            chunk_left_nxt = chunk_left_r - 13'd1;
            flag_bits_nxt  = byte_r;
            flag_idx_nxt   = 3'd0;
            phase_nxt      = (chunk_left_nxt == 13'd0) ? PH_HDR_LO : PH_ITEM;
          end
          PH_ITEM: begin
            if (!flag_bits_r[flag_idx_r]) begin
              chunk_left_nxt = chunk_left_r - 13'd1;
              we   = 1'b1;
              produced_nxt = produced_r + 13'd1;
              r_ov = 1'b1;
              r_ob = byte_r;
              sum = 14'(produced_nxt) + 14'(copy_left_r);
              if (chunk_left_nxt == 13'd0) phase_nxt = PH_HDR_LO;
              else if (sum >= 14'(CHUNK_BYTES)) phase_nxt = PH_SKIP;
              else if (flag_idx_r == 3'd7) phase_nxt = PH_FLAGS;
              else begin
                flag_idx_nxt = flag_idx_r + 3'd1;
                phase_nxt    = PH_ITEM;
              end
            end else if (chunk_left_r < 13'd2) begin
              chunk_left_nxt = 13'd0;
              phase_nxt      = PH_HDR_LO;
            end else begin
              chunk_left_nxt = chunk_left_r - 13'd1;
              tok_lo_nxt     = byte_r;
              phase_nxt      = PH_TOKEN_HI;
            end
          end
          PH_TOKEN_HI: begin
            chunk_left_nxt = chunk_left_r - 13'd1;
            if (off > produced_r) begin
              sticky_nxt = ST_BAD_BACKREF;
            end else begin
              copy_left_nxt = (len < room) ? len : room;
              copy_dist_nxt = off;
              sum = 14'(produced_r) + 14'(copy_left_nxt);
              if (chunk_left_nxt == 13'd0) phase_nxt = PH_HDR_LO;
              else if (sum >= 14'(CHUNK_BYTES)) phase_nxt = PH_SKIP;
              else if (flag_idx_r == 3'd7) phase_nxt = PH_FLAGS;
              else begin
                flag_idx_nxt = flag_idx_r + 3'd1;
                phase_nxt    = PH_ITEM;
              end
            end
          end
          PH_SKIP: begin
            chunk_left_nxt = chunk_left_r - 13'd1;
            if (chunk_left_nxt == 13'd0) phase_nxt = PH_HDR_LO;
          end
          default: ;
        endcase
        if (last_r && sticky_nxt == ST_OK) begin
          if (ph_was == PH_HDR_LO || phase_nxt == PH_HDR_LO || phase_nxt == PH_DONE) begin
            phase_nxt = PH_DONE;
          end else begin
            sticky_nxt = ST_TRUNCATED;
          end
        end
      end
      if (sticky_nxt != ST_OK) begin
        copy_left_nxt = 13'd0;
        if (sticky_nxt != ST_TRUNCATED) begin
          r_ov = 1'b0;
          r_ob = 8'd0;
        end
      end
    end
    if (sticky_nxt != ST_OK) r_stat = sticky_nxt;
    else if (r_stat == ST_BUSY) r_stat = ST_BUSY;
    else if (phase_nxt == PH_DONE && copy_left_nxt == 13'd0) r_stat = ST_ENDED;
    else r_stat = ST_OK;
  end

  // accept and retire
  always_comb begin
    busy_nxt = busy_r;
    if (finish) busy_nxt = 1'b0;
    else if (in_valid && !in_stall) busy_nxt = 1'b1;
  end

  // payload staging of the accepted request and loading of the result register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r  <= in_action;
      byte_r <= in_in_byte;
      last_r <= in_in_last;
    end
    if (finish) begin
      obyte_r <= r_ob;
      ovld_r  <= r_ov;
      opend_r <= (copy_left_nxt != 13'd0);
      ostat_r <= r_stat;
    end
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid    <= 1'b0;
      phase_r      <= PH_HDR_LO;
      hdr_lo_r     <= 8'd0;
      chunk_left_r <= 13'd0;
      flag_bits_r  <= 8'd0;
      flag_idx_r   <= 3'd0;
      produced_r   <= 13'd0;
      tok_lo_r     <= 8'd0;
      copy_left_r  <= 13'd0;
      copy_dist_r  <= 13'd0;
      sticky_r     <= ST_OK;
    end else begin
      busy_r <= busy_nxt;
      if (finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (finish) begin
        phase_r      <= phase_nxt;
        hdr_lo_r     <= hdr_lo_nxt;
        chunk_left_r <= chunk_left_nxt;
        flag_bits_r  <= flag_bits_nxt;
        flag_idx_r   <= flag_idx_nxt;
        produced_r   <= produced_nxt;
        tok_lo_r     <= tok_lo_nxt;
        copy_left_r  <= copy_left_nxt;
        copy_dist_r  <= copy_dist_nxt;
        sticky_r     <= sticky_nxt;
      end
    end
  end

  assign out_out_byte     = obyte_r;
  assign out_out_valid    = ovld_r;
  assign out_copy_pending = opend_r;
  assign out_status       = ostat_r;
  assign out_stream_done  = (ostat_r == ST_ENDED);

`include "lznt1_stream_decompressor_defines.svh"

  `LZD_ASSERT_NEXT(a_err_sticky, sticky_r != ST_OK, $stable(sticky_r), "sticky status changed")
  `LZD_ASSERT(a_err_no_copy, (sticky_r == ST_OK) || (copy_left_r == 13'd0), "copy pending after error")
  `LZD_ASSERT_NEXT(a_finish_out, finish, out_valid, "finished request without result")
  `LZD_ASSERT(a_ram_src_written, !(we && busy_r && act_r == ACT_DRAIN) || (copy_dist_r != 13'd0), "drain with zero distance")

endmodule

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lznt_pkg::*;

  // one expected result
  typedef struct {
    logic [7:0] obyte;
    logic       ovalid;
    logic       pending;
    status_t    status;
    logic       done;
  } lz_result_t;

  // decompressor model plus the store of results still awaited
  class lz_scoreboard;
    phase_t      ph;
    logic [7:0]  hdr_lo, flags, tok_lo;
    logic [7:0]  mem [4096];
    logic [12:0] left, produced, copy_left, copy_dist;
    logic [2:0]  fidx;
    logic        compressed;
    status_t     sticky;
    lz_result_t  awaited[$];
    int          fails, checked, copied, refusals;

    function new();
      ph = PH_HDR_LO;
      hdr_lo = 0; flags = 0; tok_lo = 0;
      left = 0; produced = 0; copy_left = 0; copy_dist = 0;
      fidx = 0; compressed = 0; sticky = ST_OK;
      fails = 0; checked = 0; copied = 0; refusals = 0;
    endfunction

    // phase after a literal or token inside a compressed chunk
    function void next_item();
      if (left == 0) ph = PH_HDR_LO;
      else if (int'(produced) + int'(copy_left) >= 4096) ph = PH_SKIP;
      else if (fidx >= 7) ph = PH_FLAGS;
      else begin
        fidx++;
        ph = PH_ITEM;
      end
    endfunction

    function void start_token(logic [15:0] tok);
      int sh, m, len, off, room;
      sh = 12;
      m = 'hFFF;
      if (produced > 0)
        for (int it = produced - 1; it >= 16; it = it >> 1) begin
          sh--;
          m = m >> 1;
        end
      len = (tok & m) + 3;
      off = (tok >> sh) + 1;
      if (off > produced) begin
        sticky = ST_BAD_BACKREF;
        return;
      end
      room = 4096 - produced;
      copy_left = 13'((len < room) ? len : room);
      copy_dist = 13'(off);
      next_item();
    endfunction

    // consume one byte; returns 1 when ob carries a decoded byte
    function bit push(logic [7:0] b, output logic [7:0] ob);
      logic [15:0] hdr;
      ob = 0;
      case (ph)
        PH_HDR_LO: begin
          hdr_lo = b;
          ph = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          hdr = {b, hdr_lo};
          if (hdr == 0) ph = PH_DONE;
          else if ((hdr & 16'h7000) != 16'h3000) sticky = ST_BAD_HEADER;
          else begin
            left = 13'(hdr & 16'h0FFF) + 13'd1;
            compressed = hdr[15];
            produced = 0;
            ph = compressed ? PH_FLAGS : PH_STORED;
          end
        end
        PH_STORED: begin
          left--;
          if (left == 0) ph = PH_HDR_LO;
          ob = b;
          return 1;
        end
        PH_FLAGS: begin
          left--;
          flags = b;
          fidx = 0;
          ph = (left == 0) ? PH_HDR_LO : PH_ITEM;
        end
        PH_ITEM: begin
          if (!flags[fidx]) begin
            left--;
            mem[produced[11:0]] = b;
            produced++;
            ob = b;
            next_item();
            return 1;
          end
          if (left < 2) begin
            // token cut off by the chunk end
            left = 0;
            ph = PH_HDR_LO;
          end else begin
            left--;
            tok_lo = b;
            ph = PH_TOKEN_HI;
          end
        end
        PH_TOKEN_HI: begin
          left--;
          start_token({b, tok_lo});
        end
        PH_SKIP: begin
          left--;
          if (left == 0) ph = PH_HDR_LO;
        end
        default: ;
      endcase
      return 0;
    endfunction

    function void note_request(action_t act, logic [7:0] b, logic last);
      lz_result_t e;
      logic [7:0] ob;
      logic [12:0] src;
      bit ov, refused;
      phase_t was;
      ob = 0; ov = 0; refused = 0;
      if (sticky == ST_OK) begin
        if (act == ACT_DRAIN) begin
          if (copy_left != 0) begin
            src = produced - copy_dist;
            ob = mem[src[11:0]];
            mem[produced[11:0]] = ob;
            produced++;
            copy_left--;
            ov = 1;
            copied++;
          end
        end else if (copy_left != 0) begin
          refused = 1;
          refusals++;
        end else if (ph != PH_DONE) begin
          was = ph;
          ov = push(b, ob);
          if (last && sticky == ST_OK) begin
            if (was == PH_HDR_LO || ph == PH_HDR_LO || ph == PH_DONE) ph = PH_DONE;
            else sticky = ST_TRUNCATED;
          end
        end
        if (sticky != ST_OK) begin
          copy_left = 0;
          if (sticky != ST_TRUNCATED) begin
            ov = 0;
            ob = 0;
          end
        end
      end
      if (sticky != ST_OK) e.status = sticky;
      else if (refused) e.status = ST_BUSY;
      else if (ph == PH_DONE && copy_left == 0) e.status = ST_ENDED;
      else e.status = ST_OK;
      e.obyte = ov ? ob : 8'h00;
      e.ovalid = ov;
      e.pending = (copy_left != 0);
      e.done = (e.status == ST_ENDED);
      awaited = {awaited, e};
    endfunction

    function void check_result(lz_result_t got);
      lz_result_t e;
      checked++;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("result with nothing awaited: byte %h status %0d",
                                  got.obyte, got.status);
        return;
      end
      e = awaited.pop_front();
      if (got.obyte !== e.obyte || got.ovalid !== e.ovalid || got.pending !== e.pending ||
          got.status !== e.status || got.done !== e.done) begin
        fails++;
        if (fails <= 10)
          $display("mismatch at result %0d: expected byte %h v%b p%b st%0d d%b, got byte %h v%b p%b st%0d d%b",
                   checked, e.obyte, e.ovalid, e.pending, e.status, e.done,
                   got.obyte, got.ovalid, got.pending, got.status, got.done);
      end
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_stall, in_action, in_in_last;
  logic [7:0] in_in_byte;
  logic       out_valid, out_stall, out_out_valid, out_copy_pending, out_stream_done;
  logic [7:0] out_out_byte;
  logic [2:0] out_status;

  lz_scoreboard sb;
  logic [7:0]   stream_q[$];
  int           n_sent, burst_left, idle_cycles, hold_left, stall_cyc;
  bit           held;

  lznt1_stream_decompressor u_top (.*);

  always #2 clk = ~clk;

  // receiver stall pattern, with one long hold-off once traffic is flowing
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (!held && sb.checked >= 150) begin
      held <= 1;
      hold_left <= 400;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      case ((stall_cyc / 97) % 3)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    lz_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.obyte = out_out_byte;
      got.ovalid = out_out_valid;
      got.pending = out_copy_pending;
      got.status = status_t'(out_status);
      got.done = out_stream_done;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("lznt1_stream_decompressor regression: fail");
      $finish;
    end
  end

  // one request, sent in bursts with random gaps
  task automatic send(action_t act, logic [7:0] b, logic last);
    int gap;
    @(negedge clk);
    in_valid <= 1;
    in_action <= act;
    in_in_byte <= b;
    in_in_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, b, last);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // push a stream byte, draining any pending copy first, with occasional extra pushes and drains mixed in
  task automatic push_stream_byte(logic [7:0] b, logic last);
    while (sb.copy_left != 0) begin
      if ($urandom_range(0, 19) == 0) send(ACT_PUSH, 8'($urandom), 1'b0);
      send(ACT_DRAIN, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 49) == 0) send(ACT_DRAIN, 8'($urandom), 1'($urandom));
    send(ACT_PUSH, b, last);
  endtask

  task automatic emit_all(bit last_one);
    logic [7:0] b;
    while (stream_q.size() != 0) begin
      b = stream_q.pop_front();
      push_stream_byte(b, last_one && stream_q.size() == 0);
    end
  endtask

  function automatic void put_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void add_header(logic [15:0] h);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
  endfunction

  function automatic int offset_shift(int produced);
    int sh;
    sh = 12;
    if (produced > 0)
      for (int it = produced - 1; it >= 16; it = it >> 1) sh--;
    return sh;
  endfunction

  // compressed chunk of n items with back-references only into written history
  function automatic void add_compressed(int n_items);
    logic [7:0]  body[$];
    logic [7:0]  fl;
    logic [15:0] tok;
    int produced, fpos, sh, lim, off, len, mx;
    produced = 0;
    fpos = 0;
    fl = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 8 == 0) begin
        fl = 8'($urandom);
        body = {body, fl};
        fpos = body.size() - 1;
      end
      if (fl[k % 8] && produced > 0 && produced < 4096) begin
        sh = offset_shift(produced);
        lim = (produced < (1 << (16 - sh))) ? produced : (1 << (16 - sh));
        off = $urandom_range(1, lim);
        mx = ((1 << sh) - 1 < 200) ? (1 << sh) - 1 : 200;
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, mx) : $urandom_range(0, 12);
        tok = 16'(((off - 1) << sh) | len);
        body = {body, tok[7:0]};
        body = {body, tok[15:8]};
        produced += (len + 3 < 4096 - produced) ? len + 3 : 4096 - produced;
      end else begin
        fl[k % 8] = 0;
        body[fpos] = fl;
        body = {body, 8'($urandom)};
        produced++;
      end
    end
    add_header(16'hB000 | 16'(body.size() - 1));
    foreach (body[i]) put_byte(body[i]);
  endfunction

  function automatic void add_stored(int n);
    add_header(16'h3000 | 16'(n - 1));
    repeat (n) put_byte(8'($urandom));
  endfunction

  initial begin
    int scenario;
    sb = new();
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_action = ACT_PUSH;
    in_in_byte = 0;
    in_in_last = 0;
    out_stall = 0;
    n_sent = 0;
    burst_left = 5;
    idle_cycles = 0;
    hold_left = 0;
    stall_cyc = 0;
    held = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // directed: idle drain, extreme stored bytes, a short copy, cut-off token,
    // flag byte ending a chunk, and a long run of copied bytes
    send(ACT_DRAIN, 8'hFF, 1'b1);
    add_header(16'h3001);
    put_byte(8'h00);
    put_byte(8'hFF);
    add_header(16'hB003);
    put_byte(8'h02);
    put_byte(8'h5A);
    put_byte(8'h02);
    put_byte(8'h00);
    add_header(16'hB002);
    put_byte(8'h02);
    put_byte(8'hA5);
    put_byte(8'h07);
    add_header(16'hB000);
    put_byte(8'hFF);
    add_header(16'hB006);
    put_byte(8'h02);
    put_byte(8'h41);
    put_byte(8'hFC);
    put_byte(8'h00);
    repeat (3) put_byte(8'($urandom));
    emit_all(0);

    // random well-formed chunks
    while (n_sent < 1950) begin
      if ($urandom_range(0, 3) == 0) add_stored($urandom_range(1, 12));
      else add_compressed($urandom_range(1, 40));
      emit_all(0);
    end

    // one way of ending the stream
    scenario = $urandom_range(0, 5);
    case (scenario)
      0: add_header(16'h0000);
      1: put_byte(8'($urandom));
      2: add_compressed($urandom_range(1, 20));
      3: begin
        add_header(16'h3004);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
      end
      4: add_header(16'h4005);
      default: begin
        add_header(16'hB003);
        put_byte(8'h02);
        put_byte(8'($urandom));
        put_byte(8'h00);
        put_byte(8'h10);
      end
    endcase
    emit_all(scenario < 4);
    repeat (12) send(action_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
    @(negedge clk);
    in_valid <= 0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d copied bytes, %0d refused pushes",
             n_sent, sb.checked, sb.copied, sb.refusals);
    $display("stream ending case %0d, %0d mismatches", scenario, sb.fails);
    if (sb.fails == 0) $display("lznt1_stream_decompressor regression: pass");
    else $display("lznt1_stream_decompressor regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/lznt_pkg.sv
hdl/lznt_ram.sv
hdl/lznt1_stream_decompressor.sv
tb/tb_top.sv
